[src/i2cm_pkg.sv]
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

   // Command codes on the req_mode port
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_STOP,
      PH_WLOW,
      PH_WHIGH,
      PH_RLOW,
      PH_RHIGH
   } phase_type;

   // One tick after decode
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] wbyte;
      logic       sda;
   } item_type;

   // One result beat
   typedef struct packed {
      logic       scl_level;
      logic       sda_value;
      logic       sda_enable;
      logic       busy;
      logic       done;
      logic [7:0] read_byte;
      logic       ack_bit;
   } rsp_type;

endpackage

[src/i2cm_fifo.sv]
// Small register queue used between the engine stages.
module i2cm_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[src/i2cm_front.sv]
// Front end: decodes an incoming tick beat into a queued command item.
module i2cm_front (
   input  logic               cmd_valid,
   input  logic [1:0]         mode,
   input  logic [7:0]         write_byte,
   input  logic               sda_level,
   output i2cm_pkg::item_type item
);

   i2cm_pkg::cmd_type cmd;

   always_comb begin
      cmd = i2cm_pkg::CMD_NONE;
      if (cmd_valid) begin
         unique case (mode)
            i2cm_pkg::MODE_START: cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::MODE_STOP:  cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::MODE_WRITE: cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::MODE_READ:  cmd = i2cm_pkg::CMD_READ;
            default:              cmd = i2cm_pkg::CMD_NONE;
         endcase
      end
   end

   assign item.cmd   = cmd;
   assign item.wbyte = write_byte;
   assign item.sda   = sda_level;

endmodule

[src/i2cm_back.sv]
// Back end: bus sequencer, one tick per fired item, plus the half-period register.
module i2cm_back #(
   parameter int TIMER_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   input  logic               fire,
   input  i2cm_pkg::item_type item,
   output i2cm_pkg::rsp_type  rsp
);

   // Compare width: holds 2^TIMER_BITS and any half_period value
   localparam int CW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

   i2cm_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shifter_ff, shifter_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  sda_en_ff, sda_en_in;
   logic                  ack_ff, ack_in;
   logic [7:0]            last_read_ff, last_read_in;
   logic [15:0]           half_period_ff;

   logic [CW-1:0] half_ext, lim, eff_half, tick_next;
   logic [7:0]    rd_shift;
   logic [3:0]    bc_inc;
   logic          done;

   always_comb begin
      half_ext  = CW'(half_period_ff);
      lim       = CW'(1) << TIMER_BITS;
      tick_next = CW'(tick_ff) + CW'(1);
      if (half_period_ff == '0) begin
         eff_half = CW'(1);
      end else if (half_ext > lim) begin
         eff_half = lim;
      end else begin
         eff_half = half_ext;
      end
   end

   assign rd_shift = {shifter_ff[6:0], item.sda};
   assign bc_inc   = bit_count_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shifter_in   = shifter_ff;
      tick_in      = tick_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      sda_en_in    = sda_en_ff;
      ack_in       = ack_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE || phase_ff > i2cm_pkg::PH_RHIGH) begin
         phase_in = i2cm_pkg::PH_IDLE;
         if (item.cmd != i2cm_pkg::CMD_NONE) begin
            tick_in      = '0;
            bit_count_in = '0;
            unique case (item.cmd)
               i2cm_pkg::CMD_START: begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b1;
                  scl_in    = 1'b1;
                  phase_in  = i2cm_pkg::PH_START;
               end
               i2cm_pkg::CMD_STOP: begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b0;
                  phase_in  = i2cm_pkg::PH_STOP;
               end
               i2cm_pkg::CMD_WRITE: begin
                  scl_in     = 1'b0;
                  sda_en_in  = 1'b1;
                  sda_in     = item.wbyte[7];
                  shifter_in = {item.wbyte[6:0], 1'b0};
                  phase_in   = i2cm_pkg::PH_WLOW;
               end
               default: begin
                  shifter_in = '0;
                  sda_in     = 1'b1;
                  sda_en_in  = 1'b0;
                  phase_in   = i2cm_pkg::PH_RLOW;
               end
            endcase
         end
      end else if (tick_next < eff_half) begin
         tick_in = tick_next[TIMER_BITS-1:0];
      end else begin
         tick_in = '0;
         unique case (phase_ff)
            i2cm_pkg::PH_START: begin
               if (bit_count_ff == 4'd0) begin
                  sda_in       = 1'b0;
                  bit_count_in = 4'd1;
               end else begin
                  scl_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            end
            i2cm_pkg::PH_STOP: begin
               if (bit_count_ff == 4'd0) begin
                  scl_in       = 1'b1;
                  bit_count_in = 4'd1;
               end else if (bit_count_ff == 4'd1) begin
                  sda_in       = 1'b1;
                  bit_count_in = 4'd2;
               end else begin
                  phase_in = i2cm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            end
            i2cm_pkg::PH_WLOW: begin
               scl_in   = 1'b1;
               phase_in = i2cm_pkg::PH_WHIGH;
            end
            i2cm_pkg::PH_WHIGH: begin
               scl_in = 1'b0;
               if (bit_count_ff >= i2cm_pkg::BITS_PER_BYTE) begin
                  // ack clock ends: sample slave response
                  ack_in   = item.sda;
                  phase_in = i2cm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else begin
                  bit_count_in = bc_inc;
                  if (bc_inc == i2cm_pkg::BITS_PER_BYTE) begin
                     sda_en_in = 1'b0;
                     sda_in    = 1'b1;
                  end else begin
                     sda_in     = shifter_ff[7];
                     shifter_in = {shifter_ff[6:0], 1'b0};
                  end
                  phase_in = i2cm_pkg::PH_WLOW;
               end
            end
            i2cm_pkg::PH_RLOW: begin
               scl_in   = 1'b1;
               phase_in = i2cm_pkg::PH_RHIGH;
            end
            default: begin
               shifter_in   = rd_shift;
               scl_in       = 1'b0;
               bit_count_in = bc_inc;
               if (bc_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                  last_read_in = rd_shift;
                  phase_in     = i2cm_pkg::PH_IDLE;
                  done         = 1'b1;
               end else begin
                  phase_in = i2cm_pkg::PH_RLOW;
               end
            end
         endcase
      end
   end

   assign rsp.scl_level  = scl_in;
   assign rsp.sda_value  = sda_in;
   assign rsp.sda_enable = sda_en_in;
   assign rsp.busy       = (phase_in != i2cm_pkg::PH_IDLE);
   assign rsp.done       = done;
   assign rsp.read_byte  = last_read_in;
   assign rsp.ack_bit    = ack_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         bit_count_ff <= '0;
         shifter_ff   <= '0;
         tick_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         sda_en_ff    <= 1'b0;
         ack_ff       <= 1'b1;
         last_read_ff <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shifter_ff   <= shifter_in;
         tick_ff      <= tick_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         sda_en_ff    <= sda_en_in;
         ack_ff       <= ack_in;
         last_read_ff <= last_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cm_pkg::HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

endmodule

[src/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: front decode, tick queue, sequencer, result queue.
// Every req beat is one tick of the bus sequencer and yields exactly one rsp beat carrying the
// line levels, busy/done flags, last read byte and last ack after that tick. A command (start,
// stop, write byte, read byte) is taken only on a tick while idle; line actions follow every
// half_period ticks (0 acts as 1, values above 2^TIMER_BITS are capped). The engine takes one beat
// per clock while the tick queue holds a beat and the result queue has room. A req beat passes
// through the tick queue, then the sequencer writes its rsp beat into the result queue. Both
// queues are QUEUE_DEPTH deep, so either side may stall without stopping the other until the
// queue in between fills. Write csr_wdata (half_period) only while no beat is in flight.
module i2c_master_byte_engine #(
   parameter int TIMER_BITS  = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        push,
   output logic        full,
   input  logic        req_cmd_valid,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_write_byte,
   input  logic        req_sda_level,
   // result beats
   output logic        empty,
   input  logic        pop,
   output logic        rsp_scl_level,
   output logic        rsp_sda_value,
   output logic        rsp_sda_enable,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_ack_bit,
   // half_period register
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int IW = $bits(i2cm_pkg::item_type);
   localparam int RW = $bits(i2cm_pkg::rsp_type);

   i2cm_pkg::item_type item_dec, item_q;
   i2cm_pkg::rsp_type  rsp_next, rsp_q;
   logic [IW-1:0]      item_q_bits;
   logic [RW-1:0]      rsp_q_bits;
   logic               item_empty, rsp_full, fire;

   i2cm_front u_front (
      .cmd_valid  (req_cmd_valid),
      .mode       (req_mode),
      .write_byte (req_write_byte),
      .sda_level  (req_sda_level),
      .item       (item_dec)
   );

   // tick queue: front to sequencer
   i2cm_fifo #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (IW'(item_dec)),
      .full  (full),
      .pop   (fire),
      .rdata (item_q_bits),
      .empty (item_empty)
   );

   assign item_q = i2cm_pkg::item_type'(item_q_bits);

   // sequencer advances one tick when a tick is queued and there is room for its result
   assign fire = !item_empty && !rsp_full;

   i2cm_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item_q),
      .rsp       (rsp_next)
   );

   // result queue: sequencer to consumer
   i2cm_fifo #(
      .WIDTH (RW),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (fire),
      .wdata (RW'(rsp_next)),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_q_bits),
      .empty (empty)
   );

   assign rsp_q          = i2cm_pkg::rsp_type'(rsp_q_bits);
   assign rsp_scl_level  = rsp_q.scl_level;
   assign rsp_sda_value  = rsp_q.sda_value;
   assign rsp_sda_enable = rsp_q.sda_enable;
   assign rsp_busy_res   = rsp_q.busy;
   assign rsp_done_res   = rsp_q.done;
   assign rsp_read_byte  = rsp_q.read_byte;
   assign rsp_ack_bit    = rsp_q.ack_bit;

endmodule

[bench/i2c_master_byte_engine_tb.sv]
// Self-checking bench for the I2C master byte engine: per-tick line prediction under random stalls.
module i2c_master_byte_engine_tb;

   // No-progress limit: the longest legal quiet stretch is a sender gap plus a receiver
   // stall plus the drain before a register write, so this is many times over.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 10;
   // Drain through the tick and result queues; leave some margin.
   localparam int DRAIN_CYCLES    = 6;
   // A few ticks at the largest half period, well short of the first timed line action.
   localparam int LONG_HOLD_TICKS = 20;
   localparam int PHASE_TICKS     = 50;

   // How the bench drives the sampled SDA pin while a command runs
   typedef enum int {
      SDA_LOW,
      SDA_HIGH,
      SDA_RANDOM
   } sda_drive_type;

   // Line-level model of the engine plus the queue of line states still owed by the block.
   class tick_scoreboard;
      i2cm_pkg::phase_type phase;
      logic [3:0]          bit_cnt;
      logic [7:0]          shift_reg;
      int unsigned         tick_cnt;
      logic                scl;
      logic                sda;
      logic                sda_oe;
      logic                ack;
      logic [7:0]          read_reg;
      logic [15:0]         half;
      i2cm_pkg::rsp_type   line_q[$];
      int                  errors;
      int                  reports;
      int                  beat_idx;

      function new();
         phase     = i2cm_pkg::PH_IDLE;
         bit_cnt   = 4'd0;
         shift_reg = 8'd0;
         tick_cnt  = 0;
         scl       = 1'b1;
         sda       = 1'b1;
         sda_oe    = 1'b0;
         ack       = 1'b1;
         read_reg  = 8'd0;
         half      = i2cm_pkg::HALF_PERIOD_RESET;
         errors    = 0;
         reports   = 0;
         beat_idx  = 0;
      endfunction

      function bit busy();
         return phase != i2cm_pkg::PH_IDLE;
      endfunction

      function void set_half(logic [15:0] v);
         half = v;
      endfunction

      function void shift_out();
         sda       = shift_reg[7];
         shift_reg = shift_reg << 1;
      endfunction

      function void flag(string msg);
         errors++;
         if (reports < MAX_REPORTS) begin
            $display("%s", msg);
            reports++;
         end
      endfunction

      // Advance one tick and queue the line state that follows it
      function void note_tick(logic cv, logic [1:0] mode, logic [7:0] wb, logic sda_in);
         int unsigned       span;
         logic              done;
         i2cm_pkg::rsp_type r;
         done = 1'b0;
         span = (half == 16'd0) ? 1 : int'(half);
         if (phase == i2cm_pkg::PH_IDLE) begin
            if (cv) begin
               tick_cnt = 0;
               bit_cnt  = 4'd0;
               case (mode)
                  i2cm_pkg::MODE_START: begin
                     sda_oe = 1'b1;
                     sda    = 1'b1;
                     scl    = 1'b1;
                     phase  = i2cm_pkg::PH_START;
                  end
                  i2cm_pkg::MODE_STOP: begin
                     sda_oe = 1'b1;
                     sda    = 1'b0;
                     phase  = i2cm_pkg::PH_STOP;
                  end
                  i2cm_pkg::MODE_WRITE: begin
                     shift_reg = wb;
                     scl       = 1'b0;
                     sda_oe    = 1'b1;
                     shift_out();
                     phase     = i2cm_pkg::PH_WLOW;
                  end
                  default: begin
                     shift_reg = 8'd0;
                     sda       = 1'b1;
                     sda_oe    = 1'b0;
                     phase     = i2cm_pkg::PH_RLOW;
                  end
               endcase
            end
         end else if (tick_cnt + 1 < span) begin
            tick_cnt++;
         end else begin
            tick_cnt = 0;
            case (phase)
               i2cm_pkg::PH_START: begin
                  if (bit_cnt == 4'd0) begin
                     sda     = 1'b0;
                     bit_cnt = 4'd1;
                  end else begin
                     scl   = 1'b0;
                     phase = i2cm_pkg::PH_IDLE;
                     done  = 1'b1;
                  end
               end
               i2cm_pkg::PH_STOP: begin
                  if (bit_cnt == 4'd0) begin
                     scl     = 1'b1;
                     bit_cnt = 4'd1;
                  end else if (bit_cnt == 4'd1) begin
                     sda     = 1'b1;
                     bit_cnt = 4'd2;
                  end else begin
                     phase = i2cm_pkg::PH_IDLE;
                     done  = 1'b1;
                  end
               end
               i2cm_pkg::PH_WLOW: begin
                  scl   = 1'b1;
                  phase = i2cm_pkg::PH_WHIGH;
               end
               i2cm_pkg::PH_WHIGH: begin
                  scl = 1'b0;
                  if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
                     // end of the ninth clock: latch the slave acknowledge
                     ack   = sda_in;
                     phase = i2cm_pkg::PH_IDLE;
                     done  = 1'b1;
                  end else begin
                     bit_cnt++;
                     if (bit_cnt == i2cm_pkg::BITS_PER_BYTE) begin
                        sda_oe = 1'b0;
                        sda    = 1'b1;
                     end else begin
                        shift_out();
                     end
                     phase = i2cm_pkg::PH_WLOW;
                  end
               end
               i2cm_pkg::PH_RLOW: begin
                  scl   = 1'b1;
                  phase = i2cm_pkg::PH_RHIGH;
               end
               default: begin
                  shift_reg = {shift_reg[6:0], sda_in};
                  scl       = 1'b0;
                  bit_cnt++;
                  if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
                     read_reg = shift_reg;
                     phase    = i2cm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase = i2cm_pkg::PH_RLOW;
                  end
               end
            endcase
         end
         r.scl_level  = scl;
         r.sda_value  = sda;
         r.sda_enable = sda_oe;
         r.busy       = (phase != i2cm_pkg::PH_IDLE);
         r.done       = done;
         r.read_byte  = read_reg;
         r.ack_bit    = ack;
         line_q.push_back(r);
      endfunction

      function void check_beat(i2cm_pkg::rsp_type got);
         i2cm_pkg::rsp_type want;
         if (line_q.size() == 0) begin
            flag($sformatf("beat %0d: unexpected result %p", beat_idx, got));
         end else begin
            want = line_q.pop_front();
            if (got.scl_level !== want.scl_level || got.sda_value !== want.sda_value ||
                got.sda_enable !== want.sda_enable || got.busy !== want.busy ||
                got.done !== want.done || got.read_byte !== want.read_byte ||
                got.ack_bit !== want.ack_bit) begin
               flag($sformatf({"beat %0d: expected scl=%b sda=%b oe=%b busy=%b done=%b ",
                               "rd=%h ack=%b, got scl=%b sda=%b oe=%b busy=%b done=%b ",
                               "rd=%h ack=%b"}, beat_idx,
                              want.scl_level, want.sda_value, want.sda_enable, want.busy,
                              want.done, want.read_byte, want.ack_bit,
                              got.scl_level, got.sda_value, got.sda_enable, got.busy,
                              got.done, got.read_byte, got.ack_bit));
            end
         end
         beat_idx++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_cmd_valid;
   logic [1:0]  req_mode;
   logic [7:0]  req_write_byte;
   logic        req_sda_level;
   logic        empty;
   logic        pop;
   logic        rsp_scl_level;
   logic        rsp_sda_value;
   logic        rsp_sda_enable;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_byte;
   logic        rsp_ack_bit;
   logic        csr_we;
   logic [15:0] csr_wdata;

   tick_scoreboard sb = new();
   int   tick_total = 0;   // ticks accepted so far
   logic idling     = 1'b1; // random gaps / stalls allowed in the current phase

   i2c_master_byte_engine i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd_valid  (req_cmd_valid),
      .req_mode       (req_mode),
      .req_write_byte (req_write_byte),
      .req_sda_level  (req_sda_level),
      .empty          (empty),
      .pop            (pop),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_value  (rsp_sda_value),
      .rsp_sda_enable (rsp_sda_enable),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_ack_bit    (rsp_ack_bit),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: check every popped beat, stall pop in random bursts.
   // Outputs are read right at the edge, so we see the pre-edge values the block used.
   initial begin
      int                stall_left;
      i2cm_pkg::rsp_type got;
      pop        = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            got = '{rsp_scl_level, rsp_sda_value, rsp_sda_enable, rsp_busy_res,
                    rsp_done_res, rsp_read_byte, rsp_ack_bit};
            sb.check_beat(got);
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: any beat on either side counts as progress
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("i2c_master_byte_engine_tb: errors");
            $finish;
         end
      end
   end

   function automatic logic pick_sda(sda_drive_type how);
      case (how)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // One tick = one input beat. An optional gap goes first so push is only
   // ever lowered in a different step from the one that raises it again.
   task automatic send_tick(logic cv, logic [1:0] mode, logic [7:0] wb, logic sda_in);
      if (idling && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      push           <= 1'b1;
      req_cmd_valid  <= cv;
      req_mode       <= mode;
      req_write_byte <= wb;
      req_sda_level  <= sda_in;
      do @(posedge clock); while (full);
      sb.note_tick(cv, mode, wb, sda_in);
      tick_total++;
   endtask

   // Wait for the sequencer to go idle, issue one command, then tick it through.
   // Ticks while busy carry random commands, which the engine must ignore.
   task automatic run_command(logic [1:0] mode, logic [7:0] wb, sda_drive_type how);
      while (sb.busy())
         send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 8'($urandom),
                   pick_sda(how));
      send_tick(1'b1, mode, wb, pick_sda(how));
      while (sb.busy())
         send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 8'($urandom),
                   pick_sda(how));
   endtask

   // Register write only with nothing in flight: the sender holds off until every
   // owed beat has been popped, then lets the pipeline settle.
   task automatic set_half_period(logic [15:0] v);
      push <= 1'b0;
      while (sb.line_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_half(v);
   endtask

   // A typical bus transfer: start, address byte, some data bytes, usually a stop
   task automatic run_transfer();
      int n;
      n = $urandom_range(0, 3);
      run_command(i2cm_pkg::MODE_START, 8'($urandom), SDA_RANDOM);
      run_command(i2cm_pkg::MODE_WRITE, 8'($urandom), SDA_RANDOM);
      repeat (n)
         run_command($urandom_range(0, 1) ? i2cm_pkg::MODE_WRITE : i2cm_pkg::MODE_READ,
                     8'($urandom), SDA_RANDOM);
      if ($urandom_range(0, 7) != 0)
         run_command(i2cm_pkg::MODE_STOP, 8'($urandom), SDA_RANDOM);
   endtask

   task automatic random_phase(logic [15:0] hp, logic idle_en);
      int first;
      set_half_period(hp);
      idling = idle_en;
      first  = tick_total;
      while (tick_total - first < PHASE_TICKS) begin
         case ($urandom_range(0, 9))
            0: run_command(2'($urandom_range(0, 3)), 8'($urandom), SDA_RANDOM);
            1: repeat ($urandom_range(1, 5))
                  send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom),
                            1'($urandom_range(0, 1)));
            default: run_transfer();
         endcase
      end
   endtask

   initial begin
      reset          = 1'b1;
      push           = 1'b0;
      req_cmd_valid  = 1'b0;
      req_mode       = i2cm_pkg::MODE_START;
      req_write_byte = 8'd0;
      req_sda_level  = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = 16'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // At the reset half period: idle tick, a start, a write offered while busy
      send_tick(1'b0, i2cm_pkg::MODE_STOP, 8'h00, 1'b0);
      send_tick(1'b1, i2cm_pkg::MODE_START, 8'h00, 1'b1);
      send_tick(1'b1, i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0);
      send_tick(1'b0, i2cm_pkg::MODE_READ, 8'h00, 1'b1);

      // Zero half period behaves as one tick; walk every command and the byte extremes
      set_half_period(16'd0);
      run_command(i2cm_pkg::MODE_START, 8'h00, SDA_RANDOM);
      run_command(i2cm_pkg::MODE_WRITE, 8'h00, SDA_LOW);      // acked
      run_command(i2cm_pkg::MODE_WRITE, 8'hFF, SDA_HIGH);     // not acked
      run_command(i2cm_pkg::MODE_WRITE, 8'hA5, SDA_RANDOM);
      run_command(i2cm_pkg::MODE_WRITE, 8'h5A, SDA_RANDOM);
      run_command(i2cm_pkg::MODE_READ, 8'h00, SDA_HIGH);
      run_command(i2cm_pkg::MODE_READ, 8'hFF, SDA_LOW);
      run_command(i2cm_pkg::MODE_READ, 8'h3C, SDA_RANDOM);
      run_command(i2cm_pkg::MODE_START, 8'h00, SDA_RANDOM);   // repeated start
      run_command(i2cm_pkg::MODE_STOP, 8'h00, SDA_RANDOM);
      run_command(i2cm_pkg::MODE_STOP, 8'h00, SDA_RANDOM);    // stop with no transfer open
      run_command(i2cm_pkg::MODE_READ, 8'h00, SDA_RANDOM);    // read outside a transfer
      run_command(i2cm_pkg::MODE_START, 8'h00, SDA_RANDOM);

      // Largest half period: one start held for a few ticks with a long timer running.
      // The next phase shrinks the period and the start then finishes quickly.
      set_half_period(16'hFFFF);
      send_tick(1'b1, i2cm_pkg::MODE_START, 8'h00, 1'b1);
      repeat (LONG_HOLD_TICKS)
         send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 8'($urandom),
                   1'($urandom_range(0, 1)));

      // Random transfers over several periods, one phase with no idling in the middle,
      // and no idling at all in the tail
      random_phase(16'd1, 1'b1);
      random_phase(16'd2, 1'b1);
      random_phase(16'd3, 1'b0);
      random_phase(16'd0, 1'b1);
      random_phase(16'd4, 1'b1);
      random_phase(16'd1, 1'b1);
      random_phase(16'd2, 1'b1);
      random_phase(16'd1, 1'b0);

      push <= 1'b0;
      while (sb.line_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.line_q.size() == 0) begin
         $display("i2c_master_byte_engine_tb: clean");
      end else begin
         $display("i2c_master_byte_engine_tb: errors");
      end
      $finish;
   end

endmodule

[i2c_master_byte_engine.f]
src/i2cm_pkg.sv
src/i2cm_fifo.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_byte_engine.sv
bench/i2c_master_byte_engine_tb.sv
